### sv/assert_macros.svh
// Assertion macros shared by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

### sv/mlfq_pkg.sv
// Package with types and constants of the ready-queue scheduler.
`default_nettype none
package mlfq_pkg;
    localparam int NUM_CPUS_DEF = 4;
    localparam int NUM_PRIORITIES_DEF = 8;
    localparam int MAX_THREADS_DEF = 256;
    localparam int LOAD_W = 12;
    localparam int COUNT_W = 9;
    localparam logic [1:0] CMD_PUSH = 2'd0;
    localparam logic [1:0] CMD_POP = 2'd1;
    localparam logic [1:0] CMD_EXCH = 2'd2;
    localparam logic CFG_BASE = 1'b0;
    localparam logic CFG_ACTIVE = 1'b1;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [1:0]  cpu;
        logic [7:0]  thread_id;
        logic [2:0]  priority_req;
        logic [15:0] remaining_ticks;
        logic        fixed_priority;
        logic        to_front;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  new_priority;
        logic        got_thread;
        logic [7:0]  thread_out;
        logic [2:0]  out_priority;
        logic [14:0] timeslice;
        logic        stolen;
        logic [1:0]  from_cpu;
    } out_item_t;

    typedef struct packed {
        logic [0:0] index;
        logic [7:0] data;
    } cfg_item_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_ENQ_RD, ST_ENQ_WR, ST_FIND, ST_STEAL, ST_DEQ_RD, ST_DEQ_WR, ST_OUT
    } state_t;
endpackage
`default_nettype wire

### sv/mlfq_if.sv
// Valid/ready channel interfaces of the scheduler.
`default_nettype none
interface mlfq_in_if;
    logic valid;
    logic ready;
    mlfq_pkg::in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface mlfq_out_if;
    logic valid;
    logic ready;
    mlfq_pkg::out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface mlfq_cfg_if;
    logic valid;
    logic ready;
    mlfq_pkg::cfg_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### sv/mlfq_ram.sv
// Synchronous single-port-write, registered-read memory.
`default_nettype none
module mlfq_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### sv/mlfq_ready_queue_scheduler_top.sv
// Path to result: push via ENQ_RD, ENQ_WR; exchange then FIND, and DEQ_RD, DEQ_WR if found.
// Pop: FIND, when stealing STEAL and FIND, then DEQ_RD, DEQ_WR if found; unused command to OUT.
// Throughput: one transfer at a time; input is taken again the cycle after the result transfer.
// Lists live in a link memory and a head/tail memory, each with a registered read.
// Reset clears the nonempty bits, ready counts and loads, and sets base 4 and active 1, at once.
// No clearing pass follows reset.
`default_nettype none
`include "assert_macros.svh"
module mlfq_ready_queue_scheduler_top #(
    parameter int NUM_CPUS = mlfq_pkg::NUM_CPUS_DEF,
    parameter int NUM_PRIORITIES = mlfq_pkg::NUM_PRIORITIES_DEF,
    parameter int MAX_THREADS = mlfq_pkg::MAX_THREADS_DEF
) (
    input wire logic clk,
    input wire logic rst_n,
    mlfq_in_if.sink  in_ch,
    mlfq_out_if.source out_ch,
    mlfq_cfg_if.sink cfg_ch
);
    localparam int NQ = NUM_CPUS * NUM_PRIORITIES;
    localparam int CW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int PW = $clog2(NUM_PRIORITIES);
    localparam int TW = $clog2(MAX_THREADS);
    localparam int QW = (NQ > 1) ? $clog2(NQ) : 1;
    localparam int LW = mlfq_pkg::LOAD_W;
    localparam int NW = mlfq_pkg::COUNT_W;
    localparam logic [LW-1:0] LOAD_MAX = {LW{1'b1}};
    localparam logic [NW-1:0] COUNT_MAX = {NW{1'b1}};

    mlfq_pkg::state_t state_reg, state_next;
    mlfq_pkg::in_item_t it_reg;
    mlfq_pkg::out_item_t res_reg;
    logic [7:0] base_reg;
    logic [2:0] active_reg;
    logic [NQ-1:0] ne_reg;
    logic [NW-1:0] cnt_reg [NUM_CPUS];
    logic [LW-1:0] load_reg [NUM_CPUS];
    logic [CW-1:0] cpu_reg, src_reg;
    logic [PW-1:0] lvl_reg;
    logic [TW-1:0] tid_reg;
    logic [QW-1:0] q_reg;
    logic front_reg;

    // Head/tail memory: each word holds {head, tail}.
    logic ht_we;
    logic [QW-1:0] ht_waddr, ht_raddr;
    logic [2*TW-1:0] ht_wdata, ht_rdata;
    logic nl_we;
    logic [TW-1:0] nl_waddr, nl_raddr, nl_wdata, nl_rdata;

    mlfq_ram #(.DEPTH(NQ), .WIDTH(2*TW)) u_ht (
        .clk(clk), .we(ht_we), .waddr(ht_waddr), .wdata(ht_wdata),
        .raddr(ht_raddr), .rdata(ht_rdata));
    mlfq_ram #(.DEPTH(MAX_THREADS), .WIDTH(TW)) u_nl (
        .clk(clk), .we(nl_we), .waddr(nl_waddr), .wdata(nl_wdata),
        .raddr(nl_raddr), .rdata(nl_rdata));

    logic [TW-1:0] head_rd, tail_rd;
    assign head_rd = ht_rdata[2*TW-1:TW];
    assign tail_rd = ht_rdata[TW-1:0];

    // Input decode.
    logic [CW-1:0] in_cpu;
    logic [PW-1:0] in_prio, new_prio;
    logic [22:0] slice_in;
    logic signed [15:0] rem;
    logic [2:0] np_out;
    assign in_cpu = CW'(32'(in_ch.data.cpu) % NUM_CPUS);
    assign in_prio = (32'(in_ch.data.priority_req) >= NUM_PRIORITIES) ?
        PW'(NUM_PRIORITIES - 1) : PW'(in_ch.data.priority_req);
    assign rem = in_ch.data.remaining_ticks;
    assign slice_in = 23'(base_reg) << in_prio;

    always_comb
    begin
        if (in_ch.data.fixed_priority
            || (rem > 16'sd0 && 32'(rem) < 32'(slice_in >> 1)))
        begin
            new_prio = in_prio;
        end
        else if (rem < 16'sd1)
        begin
            new_prio = (32'(in_prio) < NUM_PRIORITIES - 1) ? in_prio + PW'(1) : in_prio;
        end
        else
        begin
            new_prio = (in_prio > PW'(1)) ? in_prio - PW'(1) : in_prio;
        end
    end

    assign np_out = (in_ch.data.cmd == mlfq_pkg::CMD_PUSH) ? 3'(new_prio) :
        ((in_ch.data.cmd == mlfq_pkg::CMD_EXCH) ?
         3'(in_ch.data.to_front ? in_prio : new_prio) : 3'd0);

    // Highest-priority nonempty level of the source CPU.
    logic [NUM_PRIORITIES-1:0] ne_row;
    logic found_lvl;
    logic [PW-1:0] first_lvl;
    always_comb
    begin
        for (int p = 0; p < NUM_PRIORITIES; p++)
        begin
            ne_row[p] = ne_reg[32'(src_reg) * NUM_PRIORITIES + p];
        end
        found_lvl = 1'b0;
        first_lvl = '0;
        for (int p = NUM_PRIORITIES - 1; p >= 0; p--)
        begin
            if (ne_row[p])
            begin
                found_lvl = 1'b1;
                first_lvl = PW'(p);
            end
        end
    end

    // Steal victim choice.
    logic victim_ok;
    logic [CW-1:0] victim;
    logic [LW-1:0] best;
    always_comb
    begin
        victim_ok = 1'b0;
        victim = '0;
        best = '0;
        for (int i = 0; i < NUM_CPUS; i++)
        begin
            if (CW'(i) != cpu_reg && cnt_reg[i] != '0 && load_reg[i] > best)
            begin
                best = load_reg[i];
                victim = CW'(i);
                victim_ok = 1'b1;
            end
        end
    end

    function automatic logic [LW-1:0] sat_add(input logic [LW-1:0] v,
                                              input logic signed [LW+1:0] d);
        logic signed [LW+2:0] s;
        begin
            s = $signed({3'b0, v}) + (LW+3)'(d);
            if (s < 0) sat_add = '0;
            else if (s > $signed({3'b0, LOAD_MAX})) sat_add = LOAD_MAX;
            else sat_add = s[LW-1:0];
        end
    endfunction

    logic [QW-1:0] q_in;
    assign q_in = QW'(32'(in_cpu) * NUM_PRIORITIES
        + ((in_ch.data.cmd == mlfq_pkg::CMD_EXCH && in_ch.data.to_front) ?
           32'(in_prio) : 32'(new_prio)));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mlfq_pkg::ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    if (in_ch.data.cmd == mlfq_pkg::CMD_PUSH
                        || in_ch.data.cmd == mlfq_pkg::CMD_EXCH)
                    begin
                        state_next = mlfq_pkg::ST_ENQ_RD;
                    end
                    else if (in_ch.data.cmd == mlfq_pkg::CMD_POP)
                    begin
                        state_next = mlfq_pkg::ST_FIND;
                    end
                    else
                    begin
                        state_next = mlfq_pkg::ST_OUT;
                    end
                end
            end
            mlfq_pkg::ST_ENQ_RD: state_next = mlfq_pkg::ST_ENQ_WR;
            mlfq_pkg::ST_ENQ_WR:
                state_next = (it_reg.cmd == mlfq_pkg::CMD_EXCH) ?
                    mlfq_pkg::ST_FIND : mlfq_pkg::ST_OUT;
            mlfq_pkg::ST_FIND:
            begin
                if (found_lvl) state_next = mlfq_pkg::ST_DEQ_RD;
                else if (it_reg.cmd == mlfq_pkg::CMD_POP && active_reg >= 3'd2
                         && src_reg == cpu_reg && victim_ok)
                    state_next = mlfq_pkg::ST_STEAL;
                else state_next = mlfq_pkg::ST_OUT;
            end
            mlfq_pkg::ST_STEAL: state_next = mlfq_pkg::ST_FIND;
            mlfq_pkg::ST_DEQ_RD: state_next = mlfq_pkg::ST_DEQ_WR;
            mlfq_pkg::ST_DEQ_WR: state_next = mlfq_pkg::ST_OUT;
            mlfq_pkg::ST_OUT: if (out_ch.ready) state_next = mlfq_pkg::ST_IDLE;
            default: state_next = mlfq_pkg::ST_IDLE;
        endcase
    end

    // Memory port control.
    always_comb
    begin
        ht_we = 1'b0;
        ht_waddr = q_reg;
        ht_wdata = {tid_reg, tid_reg};
        ht_raddr = q_reg;
        nl_we = 1'b0;
        nl_waddr = tid_reg;
        nl_wdata = tid_reg;
        nl_raddr = head_rd;
        case (state_reg)
            mlfq_pkg::ST_ENQ_WR:
            begin
                ht_we = 1'b1;
                if (!ne_reg[q_reg])
                begin
                    ht_wdata = {tid_reg, tid_reg};
                end
                else if (front_reg)
                begin
                    ht_wdata = {tid_reg, tail_rd};
                    nl_we = 1'b1;
                    nl_waddr = tid_reg;
                    nl_wdata = head_rd;
                end
                else
                begin
                    ht_wdata = {head_rd, tid_reg};
                    nl_we = 1'b1;
                    nl_waddr = tail_rd;
                    nl_wdata = tid_reg;
                end
            end
            mlfq_pkg::ST_FIND:
            begin
                ht_raddr = QW'(32'(src_reg) * NUM_PRIORITIES + 32'(first_lvl));
            end
            mlfq_pkg::ST_DEQ_WR:
            begin
                ht_we = (head_rd != tail_rd);
                ht_wdata = {nl_rdata, tail_rd};
            end
            default:
            begin
                ht_we = 1'b0;
            end
        endcase
    end

    assign in_ch.ready = (state_reg == mlfq_pkg::ST_IDLE);
    assign out_ch.valid = (state_reg == mlfq_pkg::ST_OUT);
    assign out_ch.data = res_reg;
    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mlfq_pkg::ST_IDLE;
            base_reg <= 8'd4;
            active_reg <= 3'd1;
            ne_reg <= '0;
            for (int i = 0; i < NUM_CPUS; i++)
            begin
                cnt_reg[i] <= '0;
                load_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_ch.valid)
            begin
                if (cfg_ch.data.index == mlfq_pkg::CFG_BASE) base_reg <= cfg_ch.data.data;
                else active_reg <= cfg_ch.data.data[2:0];
            end
            case (state_reg)
                mlfq_pkg::ST_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        if (in_ch.data.cmd == mlfq_pkg::CMD_PUSH)
                        begin
                            load_reg[in_cpu] <= sat_add(load_reg[in_cpu],
                                (LW+2)'(NUM_PRIORITIES) - (LW+2)'(new_prio));
                        end
                        else if (in_ch.data.cmd == mlfq_pkg::CMD_EXCH && !in_ch.data.to_front)
                        begin
                            load_reg[in_cpu] <= sat_add(load_reg[in_cpu],
                                (LW+2)'(in_prio) - (LW+2)'(new_prio));
                        end
                        if ((in_ch.data.cmd == mlfq_pkg::CMD_PUSH
                             || in_ch.data.cmd == mlfq_pkg::CMD_EXCH)
                            && cnt_reg[in_cpu] != COUNT_MAX)
                        begin
                            cnt_reg[in_cpu] <= cnt_reg[in_cpu] + NW'(1);
                        end
                    end
                end
                mlfq_pkg::ST_ENQ_WR: ne_reg[q_reg] <= 1'b1;
                mlfq_pkg::ST_DEQ_WR:
                begin
                    if (head_rd == tail_rd) ne_reg[q_reg] <= 1'b0;
                    if (cnt_reg[src_reg] != '0) cnt_reg[src_reg] <= cnt_reg[src_reg] - NW'(1);
                    if (src_reg != cpu_reg)
                    begin
                        load_reg[src_reg] <= sat_add(load_reg[src_reg],
                            (LW+2)'(lvl_reg) - (LW+2)'(NUM_PRIORITIES));
                        load_reg[cpu_reg] <= sat_add(load_reg[cpu_reg],
                            (LW+2)'(NUM_PRIORITIES) - (LW+2)'(lvl_reg));
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            mlfq_pkg::ST_IDLE:
            begin
                it_reg <= in_ch.data;
                cpu_reg <= in_cpu;
                src_reg <= in_cpu;
                tid_reg <= TW'(32'(in_ch.data.thread_id) % MAX_THREADS);
                front_reg <= (in_ch.data.cmd == mlfq_pkg::CMD_EXCH) && in_ch.data.to_front;
                q_reg <= q_in;
                res_reg <= {np_out, 30'd0};
            end
            mlfq_pkg::ST_FIND:
            begin
                q_reg <= QW'(32'(src_reg) * NUM_PRIORITIES + 32'(first_lvl));
                lvl_reg <= first_lvl;
            end
            mlfq_pkg::ST_STEAL: src_reg <= victim;
            mlfq_pkg::ST_DEQ_WR:
            begin
                res_reg <= {res_reg.new_priority, 1'b1, 8'(head_rd), 3'(lvl_reg),
                    15'(23'(base_reg) << lvl_reg), (src_reg != cpu_reg), 2'(src_reg)};
            end
            default:
            begin
            end
        endcase
    end

    `ASSERT_IMPL(a_in_idle, clk, rst_n, in_ch.ready, !out_ch.valid)
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_ch.valid && !out_ch.ready,
        out_ch.valid && $stable(out_ch.data))
    `ASSERT_IMPL(a_stolen_got, clk, rst_n, out_ch.valid && out_ch.data.stolen,
        out_ch.data.got_thread)
endmodule
`default_nettype wire

### test/mlfq_ready_queue_scheduler_top_test.sv
// Self-checking testbench of the ready-queue scheduler with its own queue and load tracker.
`timescale 1ns / 1ps
module mlfq_ready_queue_scheduler_top_test;
    localparam logic [1:0] CMD_NONE = 2'd3;
    localparam int CPUS = 4;
    localparam int LEVELS = 8;
    localparam int THREADS = 256;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct {
        mlfq_pkg::in_item_t   item;
        bit                   typed;
        mlfq_pkg::out_item_t  result;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    mlfq_in_if  in_ch();
    mlfq_out_if out_ch();
    mlfq_cfg_if cfg_ch();

    mlfq_ready_queue_scheduler_top DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch),
        .out_ch(out_ch),
        .cfg_ch(cfg_ch)
    );

    always #6 clk = ~clk;

    int        link_mem [THREADS];
    int        head_mem [CPUS * LEVELS];
    int        tail_mem [CPUS * LEVELS];
    bit        busy_q [CPUS * LEVELS];
    int        ready_cnt [CPUS];
    int        load [CPUS];
    int        slice_base = 4;
    int        cpus_on = 1;
    mlfq_pkg::out_item_t pending_results [$];
    int        errors = 0;
    int        sent = 0;
    int        cycles = 0;
    bit        hold_off = 1'b0;
    bit        no_idle = 1'b0;

    function automatic void add_load(int c, int d);
        int v;
        v = load[c] + d;
        load[c] = v < 0 ? 0 : (v > 4095 ? 4095 : v);
    endfunction

    function automatic int next_level(int p, int rem, bit fixed);
        int half;
        half = (slice_base << p) / 2;
        if (fixed || (rem > 0 && rem < half))
            return p;
        if (rem < 1)
            return p < LEVELS - 1 ? p + 1 : p;
        return p > 1 ? p - 1 : p;
    endfunction

    function automatic void link_in(int q, int t, bit at_head);
        if (!busy_q[q])
        begin
            head_mem[q] = t;
            tail_mem[q] = t;
            busy_q[q] = 1'b1;
        end
        else if (at_head)
        begin
            link_mem[t] = head_mem[q];
            head_mem[q] = t;
        end
        else
        begin
            link_mem[tail_mem[q]] = t;
            tail_mem[q] = t;
        end
    endfunction

    function automatic bit dequeue(int c, output int lvl, output int t);
        int q;
        for (int p = 0; p < LEVELS; p++)
        begin
            q = c * LEVELS + p;
            if (busy_q[q])
            begin
                t = head_mem[q];
                if (head_mem[q] == tail_mem[q])
                    busy_q[q] = 1'b0;
                else
                    head_mem[q] = link_mem[t];
                if (ready_cnt[c] > 0)
                    ready_cnt[c]--;
                lvl = p;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic mlfq_pkg::out_item_t schedule(mlfq_pkg::in_item_t it);
        mlfq_pkg::out_item_t r;
        int c, p, np, lvl, t, src, best, share;
        bit got, took, found;
        r = '0;
        c = it.cpu;
        p = it.priority_req;
        np = 0;
        lvl = 0;
        t = 0;
        src = c;
        got = 1'b0;
        took = 1'b0;
        found = 1'b0;
        best = 0;
        if (it.cmd == mlfq_pkg::CMD_PUSH)
        begin
            np = next_level(p, $signed(it.remaining_ticks), it.fixed_priority);
            add_load(c, LEVELS - np);
            if (ready_cnt[c] < 511)
                ready_cnt[c]++;
            link_in(c * LEVELS + np, it.thread_id, 1'b0);
        end
        else if (it.cmd == mlfq_pkg::CMD_POP)
        begin
            got = dequeue(c, lvl, t);
            if (!got && cpus_on >= 2)
            begin
                for (int i = 0; i < CPUS; i++)
                begin
                    if (i != c && ready_cnt[i] > 0 && load[i] > best)
                    begin
                        best = load[i];
                        src = i;
                        found = 1'b1;
                    end
                end
                if (found && dequeue(src, lvl, t))
                begin
                    share = LEVELS - lvl;
                    add_load(src, -share);
                    add_load(c, share);
                    got = 1'b1;
                    took = 1'b1;
                end
            end
        end
        else if (it.cmd == mlfq_pkg::CMD_EXCH)
        begin
            if (it.to_front)
            begin
                np = p;
                link_in(c * LEVELS + p, it.thread_id, 1'b1);
            end
            else
            begin
                np = next_level(p, $signed(it.remaining_ticks), it.fixed_priority);
                add_load(c, p - np);
                link_in(c * LEVELS + np, it.thread_id, 1'b0);
            end
            if (ready_cnt[c] < 511)
                ready_cnt[c]++;
            got = dequeue(c, lvl, t);
        end
        if (it.cmd == mlfq_pkg::CMD_PUSH || it.cmd == mlfq_pkg::CMD_EXCH)
            r.new_priority = 3'(np);
        if (got)
        begin
            r.got_thread = 1'b1;
            r.thread_out = 8'(t);
            r.out_priority = 3'(lvl);
            r.timeslice = 15'(slice_base << lvl);
            r.stolen = took;
            r.from_cpu = 2'(src);
        end
        return r;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            $display("%0t ns: %s expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("mlfq_ready_queue_scheduler_top: mismatch");
            $finish;
        end
        if (hold_off)
            out_ch.ready <= 1'b0;
        else if (no_idle)
            out_ch.ready <= 1'b1;
        else
            out_ch.ready <= $urandom_range(99) >= 26;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t ns: unexpected transfer, actual %h", $time, out_ch.data);
                errors++;
            end
            else
            begin
                mlfq_pkg::out_item_t e;
                e = pending_results.pop_front();
                check_field("new_priority", e.new_priority, out_ch.data.new_priority);
                check_field("got_thread", e.got_thread, out_ch.data.got_thread);
                check_field("thread_out", e.thread_out, out_ch.data.thread_out);
                check_field("out_priority", e.out_priority, out_ch.data.out_priority);
                check_field("timeslice", e.timeslice, out_ch.data.timeslice);
                check_field("stolen", e.stolen, out_ch.data.stolen);
                check_field("from_cpu", e.from_cpu, out_ch.data.from_cpu);
            end
        end
    end

    initial
    begin
        wait (sent >= 200);
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
    end

    task automatic send(mlfq_pkg::in_item_t it, bit typed, mlfq_pkg::out_item_t want);
        mlfq_pkg::out_item_t r;
        if (!no_idle)
        begin
            while ($urandom_range(99) < 26)
            begin
                in_ch.valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= it;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        r = schedule(it);
        pending_results.push_back(typed ? want : r);
        sent++;
    endtask

    task automatic write_reg(logic idx, int value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= '{index: idx, data: value[7:0]};
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        if (idx == mlfq_pkg::CFG_BASE)
            slice_base = value & 8'hFF;
        else
            cpus_on = value & 3'h7;
        @(posedge clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    function automatic mlfq_pkg::in_item_t random_item();
        mlfq_pkg::in_item_t it;
        int k;
        k = $urandom_range(99);
        it.cmd = k < 45 ? mlfq_pkg::CMD_PUSH : (k < 80 ? mlfq_pkg::CMD_POP :
            (k < 96 ? mlfq_pkg::CMD_EXCH : CMD_NONE));
        it.cpu = 2'($urandom_range(3));
        it.thread_id = 8'($urandom_range(255));
        it.priority_req = 3'($urandom_range(7));
        if ($urandom_range(1))
            it.remaining_ticks = 16'($urandom_range(74) - 4);
        else
            it.remaining_ticks = 16'($urandom_range(16'hFFFF));
        it.fixed_priority = $urandom_range(9) == 0;
        it.to_front = 1'($urandom_range(1));
        return it;
    endfunction

    row_t directed [$] = '{
        '{'{mlfq_pkg::CMD_POP, 2'd0, 8'd0, 3'd0, 16'd0, 1'b0, 1'b0}, 1'b1, '0},
        '{'{CMD_NONE, 2'd3, 8'd255, 3'd7, 16'hFFFF, 1'b1, 1'b1}, 1'b1, '0},
        '{'{mlfq_pkg::CMD_PUSH, 2'd0, 8'd255, 3'd7, 16'h8000, 1'b0, 1'b0}, 1'b1,
          '{3'd7, 1'b0, 8'd0, 3'd0, 15'd0, 1'b0, 2'd0}},
        '{'{mlfq_pkg::CMD_PUSH, 2'd3, 8'd0, 3'd0, 16'h7FFF, 1'b0, 1'b0}, 1'b1, '0},
        '{'{mlfq_pkg::CMD_PUSH, 2'd0, 8'd1, 3'd3, 16'd1, 1'b1, 1'b0}, 1'b1,
          '{3'd3, 1'b0, 8'd0, 3'd0, 15'd0, 1'b0, 2'd0}},
        '{'{mlfq_pkg::CMD_PUSH, 2'd0, 8'd2, 3'd2, 16'd3, 1'b0, 1'b0}, 1'b1,
          '{3'd2, 1'b0, 8'd0, 3'd0, 15'd0, 1'b0, 2'd0}},
        '{'{mlfq_pkg::CMD_PUSH, 2'd1, 8'd3, 3'd5, 16'd1000, 1'b0, 1'b0}, 1'b1,
          '{3'd4, 1'b0, 8'd0, 3'd0, 15'd0, 1'b0, 2'd0}},
        '{'{mlfq_pkg::CMD_PUSH, 2'd2, 8'd170, 3'd1, 16'd100, 1'b0, 1'b0}, 1'b0, '0},
        '{'{mlfq_pkg::CMD_EXCH, 2'd0, 8'd4, 3'd6, 16'd0, 1'b0, 1'b1}, 1'b0, '0},
        '{'{mlfq_pkg::CMD_EXCH, 2'd0, 8'd5, 3'd1, 16'd0, 1'b0, 1'b0}, 1'b0, '0},
        '{'{mlfq_pkg::CMD_EXCH, 2'd2, 8'd85, 3'd4, 16'd5, 1'b1, 1'b0}, 1'b0, '0},
        '{'{mlfq_pkg::CMD_POP, 2'd0, 8'd0, 3'd0, 16'd0, 1'b0, 1'b0}, 1'b0, '0},
        '{'{mlfq_pkg::CMD_POP, 2'd0, 8'd0, 3'd0, 16'd0, 1'b0, 1'b0}, 1'b0, '0},
        '{'{mlfq_pkg::CMD_POP, 2'd0, 8'd0, 3'd0, 16'd0, 1'b0, 1'b0}, 1'b0, '0},
        '{'{mlfq_pkg::CMD_POP, 2'd0, 8'd0, 3'd0, 16'd0, 1'b0, 1'b0}, 1'b0, '0},
        '{'{mlfq_pkg::CMD_POP, 2'd3, 8'd0, 3'd0, 16'd0, 1'b0, 1'b0}, 1'b0, '0},
        '{'{mlfq_pkg::CMD_POP, 2'd1, 8'd0, 3'd0, 16'd0, 1'b0, 1'b0}, 1'b0, '0},
        '{'{mlfq_pkg::CMD_POP, 2'd1, 8'd0, 3'd0, 16'd0, 1'b0, 1'b0}, 1'b0, '0}
    };

    int bases [5] = '{255, 1, 37, 128, 4};
    int actives [5] = '{4, 2, 3, 1, 4};

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[i])
            send(directed[i].item, directed[i].typed, directed[i].result);
        for (int ph = 0; ph < 5; ph++)
        begin
            drain();
            write_reg(mlfq_pkg::CFG_BASE, bases[ph]);
            write_reg(mlfq_pkg::CFG_ACTIVE, actives[ph]);
            for (int n = 0; n < 130; n++)
            begin
                no_idle = ph == 2 && n >= 20 && n < 100;
                send(random_item(), 1'b0, '0);
            end
            no_idle = 1'b0;
        end
        drain();
        if (errors == 0)
            $display("mlfq_ready_queue_scheduler_top: match");
        else
            $display("mlfq_ready_queue_scheduler_top: mismatch");
        $finish;
    end
endmodule

### filelist.f
+incdir+sv
sv/mlfq_pkg.sv
sv/mlfq_if.sv
sv/mlfq_ram.sv
sv/mlfq_ready_queue_scheduler_top.sv
test/mlfq_ready_queue_scheduler_top_test.sv
